// ===== rtl/sbad_pkg.sv =====
// Shared constants for the signed binary to ASCII decimal converter.
package sbad_pkg;

    // Default width of the signed input value.
    localparam int VALUE_BITS_DEF = 16;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // ASCII codes of the emitted characters.
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    // BCD digits at or above this threshold get the add-3 correction.
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

// ===== rtl/signed_binary_to_ascii_decimal.sv =====
// Top level of the signed binary to ASCII decimal text converter.
//
// Usage:
//   Input: drive value and raise start; the value is taken at a rising
//   edge where start is high and busy is low. busy rises only when the
//   two-entry input queue is full, so two values can be handed over while
//   a third is being emitted.
//   Output: each text byte appears on text_byte for exactly one cycle with
//   strobe high. A run is an optional '-', the decimal digits with no
//   leading zeros ("0" for zero), then CR and LF; last marks the LF.
//   The receiver cannot stall; every strobed beat must be taken.
// Sequence per value: the value is loaded, then converted by shift-add-3
//   (one magnitude bit per cycle), then the leading digit is located, then
//   the bytes go out at one cycle per output byte (3 to 8 at 16 bits).
//   The converter takes no new item until the LF of the last one is out;
//   the bit-serial BCD loop and the one-byte-per-cycle output set its pace.
//   The first byte leaves after the conversion and the leading-digit scan.
// Reset: rst_n clears the queue and the sequencer; no beat is in flight.
module signed_binary_to_ascii_decimal #(
    parameter int VALUE_BITS = sbad_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  strobe,
    output logic [7:0]            text_byte,
    output logic                  last
);

    logic                  q_valid;
    logic                  q_take;
    logic                  q_negative;
    logic [VALUE_BITS-1:0] q_mag;

    // Accept and classify.
    sbad_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .q_negative (q_negative),
        .q_mag      (q_mag)
    );

    // Convert and emit.
    sbad_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .q_negative (q_negative),
        .q_mag      (q_mag),
        .strobe     (strobe),
        .text_byte  (text_byte),
        .last       (last)
    );

endmodule

// ===== rtl/sbad_front.sv =====
// Front end: accept a value, split it into sign and magnitude, and queue it.
module sbad_front #(
    parameter int VALUE_BITS = sbad_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  q_valid,
    input  logic                  q_take,
    output logic                  q_negative,
    output logic [VALUE_BITS-1:0] q_mag
);

    localparam int DEPTH = sbad_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  neg_mem [DEPTH];
    logic [VALUE_BITS-1:0] mag_mem [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  push;
    logic                  pop;
    logic                  in_negative;
    logic [VALUE_BITS-1:0] in_mag;

    // Classify the incoming beat: sign bit and unsigned magnitude.
    assign in_negative = value[VALUE_BITS-1];
    assign in_mag      = in_negative ? (~value + VALUE_BITS'(1)) : value;

    assign busy    = (count_reg == CNT_W'(DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign pop     = q_take && q_valid;

    assign q_negative = neg_mem[rd_ptr_reg];
    assign q_mag      = mag_mem[rd_ptr_reg];

    // Track fill level.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers and level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Hold queued entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            neg_mem[wr_ptr_reg] <= in_negative;
            mag_mem[wr_ptr_reg] <= in_mag;
        end
    end

`ifndef SYNTH
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue level above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue level did not grow on push");

    a_ptrs_meet_empty: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("pointers differ on empty queue");
`endif

endmodule

// ===== rtl/sbad_back.sv =====
// Back end: shift-add-3 binary to BCD conversion, then byte emission.
module sbad_back #(
    parameter int VALUE_BITS = sbad_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_take,
    input  logic                  q_negative,
    input  logic [VALUE_BITS-1:0] q_mag,
    output logic                  strobe,
    output logic [7:0]            text_byte,
    output logic                  last
);

    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_SIGN,
        S_DIGIT,
        S_CR,
        S_LF
    } state_t;

    state_t                   state_reg;
    logic [VALUE_BITS-1:0]    mag_reg;
    logic [DIGITS-1:0][3:0]   bcd_reg;
    logic [DIGITS-1:0][3:0]   bcd_adj;
    logic [DIGITS-1:0][3:0]   bcd_next;
    logic                     neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         lead_idx;
    logic                     strobe_reg;
    logic [7:0]               byte_reg;
    logic                     last_reg;

    assign q_take    = (state_reg == S_IDLE) && q_valid;
    assign strobe    = strobe_reg;
    assign text_byte = byte_reg;
    assign last      = last_reg;

    // Correct each BCD digit, then shift in the next magnitude bit.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= sbad_pkg::BCD_ADJ_MIN) ?
                         bcd_reg[i] + sbad_pkg::BCD_ADJ_ADD : bcd_reg[i];
        end
        // The bit shifted out of the top digit is always zero.
        bcd_next = (4 * DIGITS)'({bcd_adj, mag_reg[VALUE_BITS-1]});
    end

    // Find the highest nonzero digit; zero yields digit 0.
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    // Sequence conversion and emission; hold the output beat registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            byte_reg   <= '0;
            mag_reg    <= '0;
            bcd_reg    <= '0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        mag_reg   <= q_mag;
                        neg_reg   <= q_negative;
                        bcd_reg   <= '0;
                        cnt_reg   <= CNT_W'(VALUE_BITS);
                        state_reg <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    bcd_reg <= bcd_next;
                    mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    idx_reg   <= lead_idx;
                    state_reg <= neg_reg ? S_SIGN : S_DIGIT;
                end
                S_SIGN:
                begin
                    strobe_reg <= 1'b1;
                    byte_reg   <= sbad_pkg::CH_MINUS;
                    state_reg  <= S_DIGIT;
                end
                S_DIGIT:
                begin
                    strobe_reg <= 1'b1;
                    byte_reg   <= sbad_pkg::ASCII_ZERO + {4'd0, bcd_reg[idx_reg]};
                    if (idx_reg == '0)
                    begin
                        state_reg <= S_CR;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - IDX_W'(1);
                    end
                end
                S_CR:
                begin
                    strobe_reg <= 1'b1;
                    byte_reg   <= sbad_pkg::CH_CR;
                    state_reg  <= S_LF;
                end
                S_LF:
                begin
                    strobe_reg <= 1'b1;
                    last_reg   <= 1'b1;
                    byte_reg   <= sbad_pkg::CH_LF;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> strobe_reg && byte_reg == sbad_pkg::CH_LF)
        else $error("last beat is not a line feed");

    a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && byte_reg == sbad_pkg::CH_CR |=> strobe_reg && last_reg)
        else $error("carriage return not followed by closing line feed");

    a_quiet_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONV |-> !strobe_reg)
        else $error("beat emitted during conversion");

    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |=> state_reg == S_CONV)
        else $error("taken item did not start conversion");
`endif

endmodule
